@@ rtl/texture_footprint_filter_assert.svh @@
// ============================================================================
// Texture footprint filter assertion macros
// Concurrent assertion wrappers; they vanish when SYNTHESIS is defined.
// ============================================================================
`ifndef TEXTURE_FOOTPRINT_FILTER_ASSERT_SVH
`define TEXTURE_FOOTPRINT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TFF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TFF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFF_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/tff_pkg.sv @@
// ============================================================================
// Texture footprint filter package
// Fixed-point constants, widths, register indexes and sequencer states.
// ============================================================================
package tff_pkg;

    localparam int FRAC    = 16;
    localparam int TEXEL_W = 24;
    localparam int SUM_W   = 48;
    localparam int TOT_W   = 40;
    localparam int QUOT_W  = 17;

    localparam logic [16:0] FX_ONE    = 17'h10000;
    localparam logic [13:0] FX_EIGHTH = 14'h2000;

    typedef enum logic [2:0] {
        CFG_TEX_WIDTH   = 3'd0,
        CFG_TEX_HEIGHT  = 3'd1,
        CFG_GRAY_MODE   = 3'd2,
        CFG_TEX_PRESENT = 3'd3,
        CFG_KEY_ENABLE  = 3'd4,
        CFG_KEY_R       = 3'd5,
        CFG_KEY_G       = 3'd6,
        CFG_KEY_B       = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SET,
        S_NMUL,
        S_ROW,
        S_RD,
        S_ACC,
        S_LEND,
        S_KEY1,
        S_KEY2,
        S_DIV,
        S_DIVW,
        S_OUT
    } t_state;

endpackage

@@ rtl/tff_mem.sv @@
// ============================================================================
// Texture memory
// Single write port, single read port, registered read data.
// ============================================================================
module tff_mem #(
    parameter int ADDR_W = 18
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [tff_pkg::TEXEL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [tff_pkg::TEXEL_W-1:0] o_rdata
);
    import tff_pkg::*;

    logic [TEXEL_W-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tff_div.sv @@
// ============================================================================
// Colour divider
// Restoring divider for (2*sum*ONE + 255*tot) / (510*tot), one bit per cycle.
// ============================================================================
module tff_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tff_pkg::SUM_W-1:0]  i_sum,
    input  logic [tff_pkg::TOT_W-1:0]  i_tot,
    output logic                      o_done,
    output logic [tff_pkg::QUOT_W-1:0] o_quot
);
    import tff_pkg::*;

    localparam int STEPS = QUOT_W + 1;
    localparam int NUM_W = SUM_W + QUOT_W + 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_den, n_den;
    logic [STEPS-1:0] r_q, n_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             ge;

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        ge     = r_rem >= r_den;
        if (i_start) begin
            n_rem  = NUM_W'({i_sum, {(FRAC + 1){1'b0}}}) + NUM_W'({i_tot, 8'b0})
                   - NUM_W'(i_tot);
            n_den  = (NUM_W'({i_tot, 9'b0}) - NUM_W'({i_tot, 1'b0})) << (STEPS - 1);
            n_q    = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_den;
            end
            n_q   = {r_q[STEPS-2:0], ge};
            n_den = r_den >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q[QUOT_W-1:0];

endmodule

@@ rtl/texture_footprint_filter.sv @@
// ============================================================================
// Texture footprint filter
// Area-weighted box texture filter with colour key over a texel memory.
// ============================================================================
// Usage: an item transfers at a clock edge with start high and busy low.
// A texel write (req_type 0) stores one texel in that cycle and gives no
// result. A sample (req_type 1) gives one result, shown for one cycle with
// o_valid high; the receiver cannot stall it. With no texture present the
// debug colour appears in the cycle after the transfer and busy stays low.
// Otherwise a sample runs S_MUL, S_SET (and S_NMUL in gray mode), S_ROW per
// texel row, S_RD and S_ACC per covered texel, S_LEND to close the walk, the
// key compare in S_KEY1 and S_KEY2, S_DIV and S_DIVW per divided channel
// (three in colour mode, one in gray mode) and S_OUT to present the result.
// The walk through the single memory read port and the one-bit-per-cycle
// divider set how long a sample takes. The user must write configuration
// registers through the plain write port while the block is idle; the block
// does not enforce this. Reset restores the register defaults and idles the
// sequencer; the texel memory is not cleared and is undefined until written.
// ============================================================================
`include "texture_footprint_filter_assert.svh"
module texture_footprint_filter #(
    parameter int TEXEL_ADDR_W = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_addr,
    input  logic [12:0]        i_cfg_wdata,
    input  logic               i_req_type,
    input  logic [17:0]        i_texel_index,
    input  logic [7:0]         i_texel_red,
    input  logic [7:0]         i_texel_green,
    input  logic [7:0]         i_texel_blue,
    input  logic [16:0]        i_coord_u,
    input  logic [16:0]        i_coord_v,
    input  logic signed [17:0] i_half_du,
    input  logic signed [17:0] i_half_dv,
    output logic               o_valid,
    output logic [16:0]        o_color_red,
    output logic [16:0]        o_color_green,
    output logic [16:0]        o_color_blue,
    output logic               o_is_transparent,
    output logic               o_footprint_error,
    output logic               o_is_debug_color
);
    import tff_pkg::*;

    // configuration
    logic [12:0] r_tex_width, r_tex_height;
    logic        r_gray_mode, r_tex_present, r_key_enable;
    logic [7:0]  r_key_r, r_key_g, r_key_b;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    logic [16:0] r_xmin, r_xmax, r_ymin, r_ymax, n_xmin, n_xmax, n_ymin, n_ymax;
    logic        r_err, n_err;
    logic [29:0] r_xs, r_xe, r_ys, r_ye, n_xs, n_xe, n_ys, n_ye;
    logic [13:0] r_line, r_col, n_line, n_col;
    logic [13:0] r_line_start, r_line_end, r_col_start, r_col_end;
    logic [13:0] n_line_start, n_line_end, n_col_start, n_col_end;
    logic [13:0] r_dx, r_dy, n_dx, n_dy;
    logic        r_point, n_point;
    logic [27:0] r_row_base, n_row_base;
    logic [16:0] r_lf, n_lf;
    logic [33:0] r_prod, n_prod;
    logic [SUM_W-1:0] r_sr, r_sg, r_sb, n_sr, n_sg, n_sb;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic [SUM_W-1:0] r_kr, r_kg, r_kb, r_kr1, n_kr, n_kg, n_kb, n_kr1;
    logic        r_match, n_match;
    logic [1:0]  r_ch, n_ch;
    logic [16:0] r_qr, r_qg, r_qb, n_qr, n_qg, n_qb;
    logic [16:0] r_color_red, r_color_green, r_color_blue;
    logic [16:0] n_color_red, n_color_green, n_color_blue;
    logic        r_transp, r_ferr, r_debug, n_transp, n_ferr, n_debug;

    logic        accept;
    logic [12:0] tex_w, wm1, hm1;
    logic [13:0] du_cl, dv_cl, du_f, dv_f;
    logic        fp_err;
    logic [16:0] u_cl, v_cl;
    logic [17:0] u_pl, v_pl;
    logic [29:0] xspan, yspan;
    logic [13:0] dx_raw, dy_raw;
    logic [30:0] row_lo, row_hi, col_lo, col_hi;
    logic [16:0] cw, area;
    logic [31:0] raddr_full, waddr_full;
    logic [7:0]  tx_r, tx_g, tx_b;

    logic                     mem_we, mem_re;
    logic [TEXEL_ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [TEXEL_W-1:0]       mem_rdata;
    logic                     div_start, div_done;
    logic [SUM_W-1:0]         div_sum;
    logic [QUOT_W-1:0]        div_quot;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width   <= 13'd512;
            r_tex_height  <= 13'd512;
            r_gray_mode   <= 1'b0;
            r_tex_present <= 1'b0;
            r_key_enable  <= 1'b0;
            r_key_r       <= 8'd0;
            r_key_g       <= 8'd0;
            r_key_b       <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TEX_WIDTH:   r_tex_width   <= i_cfg_wdata;
                CFG_TEX_HEIGHT:  r_tex_height  <= i_cfg_wdata;
                CFG_GRAY_MODE:   r_gray_mode   <= i_cfg_wdata[0];
                CFG_TEX_PRESENT: r_tex_present <= i_cfg_wdata[0];
                CFG_KEY_ENABLE:  r_key_enable  <= i_cfg_wdata[0];
                CFG_KEY_R:       r_key_r       <= i_cfg_wdata[7:0];
                CFG_KEY_G:       r_key_g       <= i_cfg_wdata[7:0];
                CFG_KEY_B:       r_key_b       <= i_cfg_wdata[7:0];
                default:         r_key_b       <= r_key_b;
            endcase
        end
    end

    // Footprint clamping on the incoming sample.
    always_comb begin
        du_cl  = (i_half_du > $signed({4'b0, FX_EIGHTH})) ? FX_EIGHTH : i_half_du[13:0];
        dv_cl  = (i_half_dv > $signed({4'b0, FX_EIGHTH})) ? FX_EIGHTH : i_half_dv[13:0];
        fp_err = i_half_du[17] || i_half_dv[17];
        du_f   = fp_err ? 14'd0 : du_cl;
        dv_f   = fp_err ? 14'd0 : dv_cl;
        u_cl   = (i_coord_u > FX_ONE) ? FX_ONE : i_coord_u;
        v_cl   = (i_coord_v > FX_ONE) ? FX_ONE : i_coord_v;
        u_pl   = {1'b0, u_cl} + 18'(du_f);
        v_pl   = {1'b0, v_cl} + 18'(dv_f);
    end

    // Texture geometry and per-texel overlap.
    always_comb begin
        tex_w  = (r_tex_width == 13'd0) ? 13'd1 : r_tex_width;
        wm1    = tex_w - 13'd1;
        hm1    = (r_tex_height == 13'd0) ? 13'd0 : r_tex_height - 13'd1;
        xspan  = r_xe - r_xs;
        yspan  = r_ye - r_ys;
        dx_raw = (xspan[29:16] == 14'd0) ? 14'd1 : xspan[29:16];
        dy_raw = (yspan[29:16] == 14'd0) ? 14'd1 : yspan[29:16];
        row_lo = {1'b0, r_line, 16'b0};
        row_hi = {(15'(r_line) + 15'd1), 16'b0};
        if (row_lo < {1'b0, r_ys}) begin
            row_lo = {1'b0, r_ys};
        end
        if (row_hi > {1'b0, r_ye}) begin
            row_hi = {1'b0, r_ye};
        end
        col_lo = {1'b0, r_col, 16'b0};
        col_hi = {(15'(r_col) + 15'd1), 16'b0};
        if (col_lo < {1'b0, r_xs}) begin
            col_lo = {1'b0, r_xs};
        end
        if (col_hi > {1'b0, r_xe}) begin
            col_hi = {1'b0, r_xe};
        end
        cw         = 17'(col_hi - col_lo);
        area       = r_prod[32:16];
        raddr_full = 32'(r_row_base) + 32'(r_col);
        waddr_full = 32'(i_texel_index);
        tx_r       = mem_rdata[7:0];
        tx_g       = mem_rdata[15:8];
        tx_b       = mem_rdata[23:16];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req_type && r_tex_present) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SET;
            S_SET:  n_state = r_gray_mode ? S_NMUL : S_ROW;
            S_NMUL: n_state = S_ROW;
            S_ROW:  n_state = S_RD;
            S_RD:   n_state = S_ACC;
            S_ACC: begin
                if (r_point) begin
                    n_state = S_KEY1;
                end else if (r_col == r_col_end) begin
                    n_state = (r_line == r_line_end) ? S_LEND : S_ROW;
                end else begin
                    n_state = S_RD;
                end
            end
            S_LEND: n_state = (!r_gray_mode && r_tot == '0) ? S_ROW : S_KEY1;
            S_KEY1: n_state = S_KEY2;
            S_KEY2: n_state = S_DIV;
            S_DIV:  n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = (r_gray_mode || r_ch == 2'd2) ? S_OUT : S_DIV;
                end
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid = 1'b0;
        n_xmin = r_xmin; n_xmax = r_xmax; n_ymin = r_ymin; n_ymax = r_ymax;
        n_err = r_err;
        n_xs = r_xs; n_xe = r_xe; n_ys = r_ys; n_ye = r_ye;
        n_line = r_line; n_col = r_col;
        n_line_start = r_line_start; n_line_end = r_line_end;
        n_col_start = r_col_start; n_col_end = r_col_end;
        n_dx = r_dx; n_dy = r_dy;
        n_point = r_point;
        n_row_base = r_row_base;
        n_lf = r_lf;
        n_prod = r_prod;
        n_sr = r_sr; n_sg = r_sg; n_sb = r_sb; n_tot = r_tot;
        n_kr = r_kr; n_kg = r_kg; n_kb = r_kb; n_kr1 = r_kr1;
        n_match = r_match;
        n_ch = r_ch;
        n_qr = r_qr; n_qg = r_qg; n_qb = r_qb;
        n_color_red = r_color_red; n_color_green = r_color_green;
        n_color_blue = r_color_blue;
        n_transp = r_transp; n_ferr = r_ferr; n_debug = r_debug;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = waddr_full[TEXEL_ADDR_W-1:0];
        mem_raddr = raddr_full[TEXEL_ADDR_W-1:0];
        div_start = 1'b0;
        case (r_ch)
            2'd0:    div_sum = r_sr;
            2'd1:    div_sum = r_sg;
            default: div_sum = r_sb;
        endcase
        case (r_state)
            S_IDLE: begin
                if (accept && !i_req_type) begin
                    mem_we = 1'b1;
                end else if (accept && !r_tex_present) begin
                    n_valid       = 1'b1;
                    n_color_red   = i_coord_u;
                    n_color_green = 17'd0;
                    n_color_blue  = i_coord_v;
                    n_transp      = 1'b0;
                    n_ferr        = 1'b0;
                    n_debug       = 1'b1;
                end else if (accept) begin
                    n_err  = fp_err;
                    n_xmin = (u_cl > 17'(du_f)) ? u_cl - 17'(du_f) : 17'd0;
                    n_ymin = (v_cl > 17'(dv_f)) ? v_cl - 17'(dv_f) : 17'd0;
                    n_xmax = (u_pl > 18'(FX_ONE)) ? FX_ONE : u_pl[16:0];
                    n_ymax = (v_pl > 18'(FX_ONE)) ? FX_ONE : v_pl[16:0];
                end
            end
            S_MUL: begin
                n_xs = 30'(r_xmin) * 30'(wm1);
                n_xe = 30'(r_xmax) * 30'(wm1);
                n_ys = 30'(r_ymin) * 30'(hm1);
                n_ye = 30'(r_ymax) * 30'(hm1);
            end
            S_SET: begin
                n_line       = r_ys[29:16];
                n_line_start = r_ys[29:16];
                n_col        = r_xs[29:16];
                n_col_start  = r_xs[29:16];
                n_dx         = dx_raw;
                n_dy         = dy_raw;
                if (r_gray_mode) begin
                    n_col_end  = r_xs[29:16] + dx_raw - 14'd1;
                    n_line_end = r_ys[29:16] + dy_raw - 14'd1;
                end else begin
                    n_col_end  = r_xe[29:16];
                    n_line_end = r_ye[29:16];
                end
                n_point = !r_gray_mode && (r_xs[29:16] == r_xe[29:16])
                          && (r_ys[29:16] == r_ye[29:16]);
                n_sr  = '0;
                n_sg  = '0;
                n_sb  = '0;
                n_tot = '0;
            end
            S_NMUL: begin
                n_tot = 40'(r_dx) * 40'(r_dy);
            end
            S_ROW: begin
                n_row_base = 28'(r_line) * 28'(tex_w);
                n_lf       = 17'(row_hi - row_lo);
            end
            S_RD: begin
                mem_re = 1'b1;
                n_prod = 34'(r_lf) * 34'(cw);
            end
            S_ACC: begin
                if (r_point) begin
                    n_sr  = SUM_W'(tx_r);
                    n_sg  = SUM_W'(tx_g);
                    n_sb  = SUM_W'(tx_b);
                    n_tot = TOT_W'(1);
                end else begin
                    if (r_gray_mode) begin
                        n_sr = r_sr + SUM_W'(tx_r);
                    end else begin
                        n_tot = r_tot + TOT_W'(area);
                        n_sr  = r_sr + SUM_W'(tx_r) * SUM_W'(area);
                        n_sg  = r_sg + SUM_W'(tx_g) * SUM_W'(area);
                        n_sb  = r_sb + SUM_W'(tx_b) * SUM_W'(area);
                    end
                    if (r_col == r_col_end) begin
                        n_col  = r_col_start;
                        n_line = r_line + 14'd1;
                    end else begin
                        n_col = r_col + 14'd1;
                    end
                end
            end
            S_LEND: begin
                // A footprint of zero area falls back to its lower corner texel.
                n_point = 1'b1;
                n_line  = r_line_start;
                n_col   = r_col_start;
            end
            S_KEY1: begin
                n_kr  = SUM_W'(r_key_r) * SUM_W'(r_tot);
                n_kg  = SUM_W'(r_key_g) * SUM_W'(r_tot);
                n_kb  = SUM_W'(r_key_b) * SUM_W'(r_tot);
                n_kr1 = SUM_W'({1'b0, r_key_r} + 9'd1) * SUM_W'(r_tot);
            end
            S_KEY2: begin
                // Gray mode matches when the truncated average equals the key.
                if (r_gray_mode) begin
                    n_match = (r_sr >= r_kr) && (r_sr < r_kr1);
                end else begin
                    n_match = (r_sr == r_kr) && (r_sg == r_kg) && (r_sb == r_kb);
                end
                n_ch = 2'd0;
            end
            S_DIV: begin
                div_start = 1'b1;
            end
            S_DIVW: begin
                if (div_done) begin
                    if (r_gray_mode) begin
                        n_qr = div_quot;
                        n_qg = div_quot;
                        n_qb = div_quot;
                    end else begin
                        case (r_ch)
                            2'd0:    n_qr = div_quot;
                            2'd1:    n_qg = div_quot;
                            default: n_qb = div_quot;
                        endcase
                    end
                    n_ch = r_ch + 2'd1;
                end
            end
            S_OUT: begin
                n_valid       = 1'b1;
                n_color_red   = r_qr;
                n_color_green = r_qg;
                n_color_blue  = r_qb;
                n_transp      = r_key_enable && r_match;
                n_ferr        = r_err;
                n_debug       = 1'b0;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xmin <= n_xmin; r_xmax <= n_xmax; r_ymin <= n_ymin; r_ymax <= n_ymax;
        r_err <= n_err;
        r_xs <= n_xs; r_xe <= n_xe; r_ys <= n_ys; r_ye <= n_ye;
        r_line <= n_line; r_col <= n_col;
        r_line_start <= n_line_start; r_line_end <= n_line_end;
        r_col_start <= n_col_start; r_col_end <= n_col_end;
        r_dx <= n_dx; r_dy <= n_dy;
        r_point <= n_point;
        r_row_base <= n_row_base;
        r_lf <= n_lf;
        r_prod <= n_prod;
        r_sr <= n_sr; r_sg <= n_sg; r_sb <= n_sb; r_tot <= n_tot;
        r_kr <= n_kr; r_kg <= n_kg; r_kb <= n_kb; r_kr1 <= n_kr1;
        r_match <= n_match;
        r_ch <= n_ch;
        r_qr <= n_qr; r_qg <= n_qg; r_qb <= n_qb;
        r_color_red <= n_color_red;
        r_color_green <= n_color_green;
        r_color_blue <= n_color_blue;
        r_transp <= n_transp; r_ferr <= n_ferr; r_debug <= n_debug;
    end

    tff_mem #(
        .ADDR_W (TEXEL_ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({i_texel_blue, i_texel_green, i_texel_red}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_tot   (r_tot),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_valid           = r_valid;
    assign o_color_red       = r_color_red;
    assign o_color_green     = r_color_green;
    assign o_color_blue      = r_color_blue;
    assign o_is_transparent  = r_transp;
    assign o_footprint_error = r_ferr;
    assign o_is_debug_color  = r_debug;

    `TFF_ASSERT(a_debug_flags, i_clk, i_rst_n, o_valid && o_is_debug_color |-> !o_is_transparent && !o_footprint_error, "debug result carries key or error flag")
    `TFF_NEVER(a_mem_rw, i_clk, i_rst_n, mem_we && mem_re, "texel write overlaps a filter read")
    `TFF_ASSERT(a_color_range, i_clk, i_rst_n, o_valid && !o_is_debug_color |-> o_color_red <= 17'h10000 && o_color_green <= 17'h10000 && o_color_blue <= 17'h10000, "filtered colour above one")

endmodule
